[rtl/path_perceptron_branch_predictor_defines.svh]
// Assertion macros shared by the predictor RTL.
`ifndef PATH_PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH
`define PATH_PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTH
// Concurrent check on an explicit clock and active-low reset.
`define PPBP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check on the block clock and reset.
`define PPBP_ASSERT(lbl, prop, msg) \
    `PPBP_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define PPBP_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define PPBP_ASSERT(lbl, prop, msg)
`endif

`endif

[rtl/ppbp_pkg.sv]
package ppbp_pkg;

    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 48;
    localparam int TID_W      = 2;
    localparam int TID_N      = 1 << TID_W;
    localparam int THR_W      = 11;
    localparam int SUM_W      = 12;
    localparam int ADDR_DIGIT = 8;
    localparam int ADDR_STEPS = ADDR_W / ADDR_DIGIT;
    localparam int STEP_W     = $clog2(ADDR_STEPS);

    localparam logic [THR_W-1:0] THR_RESET = 11'd56;
    localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_UNCOND  = 3'd1,
        CMD_UPDATE  = 3'd2,
        CMD_SQUASH  = 3'd3,
        CMD_BTB_FIX = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_DISP,
        ST_SUM,
        ST_ADV,
        ST_COPY,
        ST_TBIAS,
        ST_TBIAS_WR,
        ST_TRD,
        ST_TWR,
        ST_DONE
    } t_state;

endpackage

[rtl/ppbp_cmd_if.sv]
interface ppbp_cmd_if;
    import ppbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
    logic              was_squashed;
    logic [TID_W-1:0]  thread_id;

    modport source (
        output valid, command, branch_address, taken, was_squashed, thread_id,
        input  ready
    );
    modport sink (
        input  valid, command, branch_address, taken, was_squashed, thread_id,
        output ready
    );
endinterface

[rtl/ppbp_res_if.sv]
interface ppbp_res_if;
    import ppbp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    predict_taken;
    logic signed [SUM_W-1:0] perceptron_sum;
    logic                    trained;

    modport source (
        output valid, predict_taken, perceptron_sum, trained,
        input  ready
    );
    modport sink (
        input  valid, predict_taken, perceptron_sum, trained,
        output ready
    );
endinterface

[rtl/ppbp_cfg_if.sv]
interface ppbp_cfg_if;
    import ppbp_pkg::*;

    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/ppbp_ram.sv]
module ppbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/path_perceptron_branch_predictor.sv]
// Path-based perceptron branch predictor, one command at a time. The command beat is taken
// only when the sequencer is idle; the result goes to an output register, so the next command
// is taken while a result waits. After reset a clearing pass zeroes the weight table and the
// partial-sum stores, during which no command is taken. The row is folded out of the address
// 8 bits per cycle; the weight memory has one write port and one read port. Unconditional,
// btb-miss fix and dropped commands finish after the fold; lookup and untrained update then
// shift the partial sums, and squash copies the committed sums into the speculative ones; a
// trained update adds a weight read-modify-write along the path (the bias alone with an empty
// path), and a copy of the partial sums when they are restored. A finished command waits while
// the output register still holds an unaccepted beat; the sequencer goes back to idle as the
// result is loaded, so the next command beat can be taken in the cycle after.
`include "path_perceptron_branch_predictor_defines.svh"

module path_perceptron_branch_predictor #(
    parameter int HISTORY_LEN = 16,
    parameter int ROWS        = 10,
    parameter int THREADS     = 4,
    parameter int WEIGHT_BITS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppbp_cmd_if.sink  i_cmd,
    ppbp_res_if.source o_res,
    ppbp_cfg_if.sink  i_cfg
);
    import ppbp_pkg::*;

    localparam int N        = HISTORY_LEN + 1;
    localparam int WT_DEPTH = ROWS * N;
    localparam int AW       = $clog2(WT_DEPTH);
    localparam int SW       = $clog2(N);
    localparam int RW       = $clog2(ROWS);
    localparam int FW       = $clog2(N + 1);
    localparam int HIW      = $clog2(HISTORY_LEN);

    localparam logic [WEIGHT_BITS-1:0] W_MAX = WEIGHT_BITS'((1 << (WEIGHT_BITS - 1)) - 1);
    localparam logic [WEIGHT_BITS-1:0] W_MIN = ~W_MAX;

    function automatic logic [SUM_W-1:0] f_sat(input logic [SUM_W:0] v);
        if (v[SUM_W] != v[SUM_W-1]) begin
            return v[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return v[SUM_W-1:0];
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] f_bump(input logic [WEIGHT_BITS-1:0] w,
                                                     input logic up);
        if (up && w != W_MAX) begin
            return w + WEIGHT_BITS'(1);
        end
        if (!up && w != W_MIN) begin
            return w - WEIGHT_BITS'(1);
        end
        return w;
    endfunction

    // control state
    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic [THR_W-1:0]    r_thr;
    logic [SW-1:0]       r_head, n_head;
    logic [FW-1:0]       r_fill, n_fill;
    logic [HISTORY_LEN-1:0] r_spec_hist [TID_N];
    logic [HISTORY_LEN-1:0] n_spec_hist [TID_N];
    logic [HISTORY_LEN-1:0] r_commit_hist [TID_N];
    logic [HISTORY_LEN-1:0] n_commit_hist [TID_N];
    logic                r_out_valid, n_out_valid;
    logic [SW-1:0]       r_cnt, n_cnt;
    logic                r_pv, n_pv;

    // payload
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_taken, n_taken;
    logic                r_sq, n_sq;
    logic [TID_W-1:0]    r_tid, n_tid;
    logic [RW-1:0]       r_row, n_row;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [AW-1:0]       r_base, n_base;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_dir, n_dir;
    logic                r_train, n_train;
    logic [HISTORY_LEN-1:0] r_hist, n_hist;
    logic [SW-1:0]       r_pi, n_pi;
    logic [SW-1:0]       r_j, n_j;
    logic [SW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_waddr, n_waddr;
    logic                r_pt, n_pt;
    logic                r_tr, n_tr;
    logic                r_out_pt, n_out_pt;
    logic [SUM_W-1:0]    r_out_sum, n_out_sum;
    logic                r_out_tr, n_out_tr;

    // memory ports
    logic                   wt_we;
    logic [AW-1:0]          wt_wa, wt_ra;
    logic [WEIGHT_BITS-1:0] wt_wd, wt_rd;
    logic                   ss_we, cs_we;
    logic [SW-1:0]          ss_wa, ss_ra, cs_wa, cs_ra;
    logic [SUM_W-1:0]       ss_wd, ss_rd, cs_wd, cs_rd;
    logic                   pr_we;
    logic [SW-1:0]          pr_wa, pr_ra;
    logic [RW-1:0]          pr_wd, pr_rd;

    // datapath helpers
    logic [RW-1:0]    fold_row;
    logic             tid_ok;
    logic [SUM_W-1:0] sums_rd;
    logic [SUM_W:0]   w_ext, s_ext;
    logic [SUM_W-1:0] adv_val, bias_sum;
    logic [SUM_W:0]   bias_ext, mag;
    logic             below_thr;
    logic [SW-1:0]    idx_init, idx_next, head_new, p_idx;
    logic [SW:0]      p_sum;
    logic             hb;
    logic [AW-1:0]    t_addr;
    logic             out_free;
    logic             issue;

    ppbp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WT_DEPTH)) u_wt (
        .i_clk(i_clk), .i_we(wt_we), .i_waddr(wt_wa), .i_wdata(wt_wd),
        .i_raddr(wt_ra), .o_rdata(wt_rd)
    );
    ppbp_ram #(.WIDTH(SUM_W), .DEPTH(N)) u_spec_sums (
        .i_clk(i_clk), .i_we(ss_we), .i_waddr(ss_wa), .i_wdata(ss_wd),
        .i_raddr(ss_ra), .o_rdata(ss_rd)
    );
    ppbp_ram #(.WIDTH(SUM_W), .DEPTH(N)) u_commit_sums (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_wa), .i_wdata(cs_wd),
        .i_raddr(cs_ra), .o_rdata(cs_rd)
    );
    // path of recent rows, circular with r_head at the newest entry
    ppbp_ram #(.WIDTH(RW), .DEPTH(N)) u_path (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_wa), .i_wdata(pr_wd),
        .i_raddr(pr_ra), .o_rdata(pr_rd)
    );

    // address mod ROWS, one byte per cycle, MSB first
    always_comb begin
        logic [RW:0]         v;
        logic [ADDR_DIGIT-1:0] dig;
        dig = r_addr[ADDR_W-1 -: ADDR_DIGIT];
        v   = {1'b0, r_row};
        for (int k = ADDR_DIGIT - 1; k >= 0; k--) begin
            v = {v[RW-1:0], dig[k]};
            if (v >= (RW+1)'(ROWS)) begin
                v = v - (RW+1)'(ROWS);
            end
        end
        fold_row = v[RW-1:0];
    end

    assign tid_ok    = int'(r_tid) < THREADS;
    assign sums_rd   = (r_cmd == CMD_UPDATE) ? cs_rd : ss_rd;
    assign w_ext     = {{(SUM_W + 1 - WEIGHT_BITS){wt_rd[WEIGHT_BITS-1]}}, wt_rd};
    assign s_ext     = {sums_rd[SUM_W-1], sums_rd};
    assign adv_val   = (r_pi == '0) ? '0 : f_sat(r_dir ? s_ext + w_ext : s_ext - w_ext);
    assign bias_sum  = f_sat({ss_rd[SUM_W-1], ss_rd} + w_ext);
    assign bias_ext  = {bias_sum[SUM_W-1], bias_sum};
    assign mag       = bias_sum[SUM_W-1] ? (~bias_ext + (SUM_W+1)'(1)) : bias_ext;
    assign below_thr = mag <= (SUM_W+1)'(r_thr);
    assign idx_init  = (r_fill == FW'(1)) ? '0 : SW'(1);
    assign idx_next  = (FW'(r_idx) + FW'(1) == r_fill) ? '0 : r_idx + SW'(1);
    assign head_new  = (r_head == '0) ? SW'(N - 1) : r_head - SW'(1);
    // history bit HISTORY_LEN lies past the register and reads as 0
    assign hb        = (r_j < SW'(HISTORY_LEN)) ? r_hist[r_j[HIW-1:0]] : 1'b0;
    assign t_addr    = AW'(pr_rd * N) + AW'(r_j);
    assign out_free  = !r_out_valid || o_res.ready;
    assign issue     = !(r_pv && r_pi == '0);

    always_comb begin
        p_idx = r_idx;
        if (r_state == ST_TBIAS_WR) begin
            p_idx = idx_init;
        end else if (r_state == ST_TWR) begin
            p_idx = idx_next;
        end
        p_sum = {1'b0, r_head} + {1'b0, p_idx};
        pr_ra = (p_sum >= (SW+1)'(N)) ? SW'(p_sum - (SW+1)'(N)) : p_sum[SW-1:0];
    end

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_head        = r_head;
        n_fill        = r_fill;
        n_spec_hist   = r_spec_hist;
        n_commit_hist = r_commit_hist;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_cnt         = r_cnt;
        n_pv          = r_pv;
        n_cmd         = r_cmd;
        n_addr        = r_addr;
        n_taken       = r_taken;
        n_sq          = r_sq;
        n_tid         = r_tid;
        n_row         = r_row;
        n_step        = r_step;
        n_base        = r_base;
        n_sum         = r_sum;
        n_dir         = r_dir;
        n_train       = r_train;
        n_hist        = r_hist;
        n_pi          = r_pi;
        n_j           = r_j;
        n_idx         = r_idx;
        n_waddr       = r_waddr;
        n_pt          = r_pt;
        n_tr          = r_tr;
        n_out_pt      = r_out_pt;
        n_out_sum     = r_out_sum;
        n_out_tr      = r_out_tr;

        wt_we = 1'b0;  wt_wa = r_base;  wt_wd = '0;  wt_ra = r_base;
        ss_we = 1'b0;  ss_wa = r_pi;    ss_wd = '0;  ss_ra = SW'(N - 1);
        cs_we = 1'b0;  cs_wa = r_pi;    cs_wd = '0;  cs_ra = r_cnt;
        pr_we = 1'b0;  pr_wa = head_new; pr_wd = r_row;

        case (r_state)
            ST_CLEAR: begin
                wt_we = 1'b1;
                wt_wa = r_clr_addr;
                if (int'(r_clr_addr) < N) begin
                    ss_we = 1'b1;
                    cs_we = 1'b1;
                    ss_wa = r_clr_addr[SW-1:0];
                    cs_wa = r_clr_addr[SW-1:0];
                end
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(WT_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = i_cmd.command;
                    n_addr  = i_cmd.branch_address;
                    n_taken = i_cmd.taken;
                    n_sq    = i_cmd.was_squashed;
                    n_tid   = i_cmd.thread_id;
                    n_row   = '0;
                    n_step  = '0;
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                n_row  = fold_row;
                n_addr = r_addr << ADDR_DIGIT;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(ADDR_STEPS - 1)) begin
                    n_base  = AW'(fold_row * N);
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_pt    = 1'b0;
                n_sum   = '0;
                n_tr    = 1'b0;
                n_cnt   = SW'(N - 1);
                n_pv    = 1'b0;
                n_state = ST_DONE;
                if (tid_ok) begin
                    case (r_cmd)
                        CMD_LOOKUP: begin
                            pr_we   = 1'b1;
                            n_head  = head_new;
                            n_fill  = (int'(r_fill) < N) ? r_fill + FW'(1) : r_fill;
                            n_state = ST_SUM;
                        end
                        CMD_UNCOND: begin
                            pr_we   = 1'b1;
                            n_head  = head_new;
                            n_fill  = (int'(r_fill) < N) ? r_fill + FW'(1) : r_fill;
                            n_spec_hist[r_tid] = {r_spec_hist[r_tid][HISTORY_LEN-2:0], 1'b1};
                            n_pt    = 1'b1;
                        end
                        CMD_UPDATE: begin
                            n_state = ST_SUM;
                        end
                        CMD_SQUASH: begin
                            n_spec_hist[r_tid] = r_commit_hist[r_tid];
                            n_state = ST_COPY;
                        end
                        CMD_BTB_FIX: begin
                            n_commit_hist[r_tid][0] = 1'b0;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                // bias weight and last spec partial sum were read in ST_DISP
                n_sum = bias_sum;
                if (r_cmd == CMD_UPDATE) begin
                    n_dir   = r_taken;
                    n_hist  = r_spec_hist[r_tid];
                    n_commit_hist[r_tid] = {r_commit_hist[r_tid][HISTORY_LEN-2:0], r_taken};
                    n_train = r_sq || below_thr;
                    n_tr    = r_sq || below_thr;
                end else begin
                    n_dir   = !bias_sum[SUM_W-1];
                    n_pt    = !bias_sum[SUM_W-1];
                    n_spec_hist[r_tid] = {r_spec_hist[r_tid][HISTORY_LEN-2:0],
                                          !bias_sum[SUM_W-1]};
                end
                n_state = ST_ADV;
            end
            ST_ADV: begin
                // read sums[i-1] and weight[N-i], write sums[i] in the next cycle, i descending
                ss_ra = (r_cnt != '0) ? r_cnt - SW'(1) : '0;
                cs_ra = ss_ra;
                wt_ra = (r_cnt != '0) ? r_base + AW'(N) - AW'(r_cnt) : r_base;
                if (r_pv) begin
                    if (r_cmd == CMD_UPDATE) begin
                        cs_we = 1'b1;
                        cs_wd = adv_val;
                    end else begin
                        ss_we = 1'b1;
                        ss_wd = adv_val;
                    end
                end
                if (issue) begin
                    n_pi  = r_cnt;
                    n_pv  = 1'b1;
                    n_cnt = (r_cnt != '0) ? r_cnt - SW'(1) : r_cnt;
                end else begin
                    n_pv  = 1'b0;
                    n_cnt = SW'(N - 1);
                    if (r_cmd != CMD_UPDATE || !r_train) begin
                        n_state = ST_DONE;
                    end else if (r_sq) begin
                        n_spec_hist[r_tid] = r_commit_hist[r_tid];
                        n_state = ST_COPY;
                    end else begin
                        n_state = ST_TBIAS;
                    end
                end
            end
            ST_COPY: begin
                cs_ra = r_cnt;
                if (r_pv) begin
                    ss_we = 1'b1;
                    ss_wd = cs_rd;
                end
                if (issue) begin
                    n_pi  = r_cnt;
                    n_pv  = 1'b1;
                    n_cnt = (r_cnt != '0) ? r_cnt - SW'(1) : r_cnt;
                end else begin
                    n_pv    = 1'b0;
                    n_state = (r_cmd == CMD_UPDATE) ? ST_TBIAS : ST_DONE;
                end
            end
            ST_TBIAS: begin
                wt_ra   = r_base;
                n_state = ST_TBIAS_WR;
            end
            ST_TBIAS_WR: begin
                wt_we = 1'b1;
                wt_wa = r_base;
                wt_wd = f_bump(wt_rd, r_taken);
                if (r_fill != '0) begin
                    n_idx   = idx_init;
                    n_j     = SW'(1);
                    n_state = ST_TRD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_TRD: begin
                wt_ra   = t_addr;
                n_waddr = t_addr;
                n_state = ST_TWR;
            end
            ST_TWR: begin
                wt_we = 1'b1;
                wt_wa = r_waddr;
                wt_wd = f_bump(wt_rd, hb == r_taken);
                if (r_j == SW'(N - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_j     = r_j + SW'(1);
                    n_idx   = idx_next;
                    n_state = ST_TRD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pt    = r_pt;
                    n_out_sum   = r_sum;
                    n_out_tr    = r_tr;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_thr       <= THR_RESET;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            for (int t = 0; t < TID_N; t++) begin
                r_spec_hist[t]   <= '0;
                r_commit_hist[t] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_head        <= n_head;
            r_fill        <= n_fill;
            r_out_valid   <= n_out_valid;
            r_cnt         <= n_cnt;
            r_pv          <= n_pv;
            r_spec_hist   <= n_spec_hist;
            r_commit_hist <= n_commit_hist;
            if (i_cfg.valid) begin
                r_thr <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_addr    <= n_addr;
        r_taken   <= n_taken;
        r_sq      <= n_sq;
        r_tid     <= n_tid;
        r_row     <= n_row;
        r_step    <= n_step;
        r_base    <= n_base;
        r_sum     <= n_sum;
        r_dir     <= n_dir;
        r_train   <= n_train;
        r_hist    <= n_hist;
        r_pi      <= n_pi;
        r_j       <= n_j;
        r_idx     <= n_idx;
        r_waddr   <= n_waddr;
        r_pt      <= n_pt;
        r_tr      <= n_tr;
        r_out_pt  <= n_out_pt;
        r_out_sum <= n_out_sum;
        r_out_tr  <= n_out_tr;
    end

    assign i_cmd.ready          = (r_state == ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_res.valid          = r_out_valid;
    assign o_res.predict_taken  = r_out_pt;
    assign o_res.perceptron_sum = $signed(r_out_sum);
    assign o_res.trained        = r_out_tr;

    `PPBP_ASSERT(a_pred_sign, o_res.valid && o_res.predict_taken |-> !o_res.perceptron_sum[SUM_W-1], "taken prediction with negative sum")
    `PPBP_ASSERT(a_trained_not_taken, o_res.valid && o_res.trained |-> !o_res.predict_taken, "trained result flagged as taken")
    `PPBP_ASSERT(a_fill_range, int'(r_fill) <= N, "path fill past path length")
    `PPBP_ASSERT(a_head_range, int'(r_head) < N, "path head out of range")
endmodule

[verif/ppbp_prediction_checker.sv]
// Watches the command, result and threshold channels, keeps its own copy of the
// predictor state and compares every result beat against the predicted outcome.
module ppbp_prediction_checker #(
    parameter int HISTORY_LEN = 16,
    parameter int ROWS        = 10,
    parameter int THREADS     = 4,
    parameter int WEIGHT_BITS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppbp_cmd_if  i_cmd,
    ppbp_res_if  i_res,
    ppbp_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_trained
);
    import ppbp_pkg::*;

    localparam int NWTS        = HISTORY_LEN + 1;
    localparam int WMAX        = (1 << (WEIGHT_BITS - 1)) - 1;
    localparam int WMIN        = -WMAX - 1;
    localparam int PSUM_MAX    = (1 << (SUM_W - 1)) - 1;
    localparam int PSUM_MIN    = -PSUM_MAX - 1;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int MAX_REPORTS = 10;

    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [SUM_W-1:0]       psum_t;

    typedef struct packed {
        logic  predict_taken;
        psum_t perceptron_sum;
        logic  trained;
    } outcome_t;

    weight_t                weights     [ROWS][NWTS];
    psum_t                  spec_sums   [NWTS];
    psum_t                  commit_sums [NWTS];
    logic [HISTORY_LEN-1:0] spec_hist   [THREADS];
    logic [HISTORY_LEN-1:0] commit_hist [THREADS];
    logic [ROW_W-1:0]       path_rows   [NWTS];
    int                     path_fill;
    logic [THR_W-1:0]       threshold;

    outcome_t outcome_q [$];
    int       err_cnt;
    int       checked_cnt;
    int       trained_cnt;

    function automatic psum_t clip_sum(int v);
        if (v > PSUM_MAX) return psum_t'(PSUM_MAX);
        if (v < PSUM_MIN) return psum_t'(PSUM_MIN);
        return psum_t'(v);
    endfunction

    function automatic weight_t nudge(weight_t w, logic up);
        if (up && int'(w) < WMAX) return weight_t'(int'(w) + 1);
        if (!up && int'(w) > WMIN) return weight_t'(int'(w) - 1);
        return w;
    endfunction

    function automatic void clear_state();
        for (int r = 0; r < ROWS; r++)
            for (int i = 0; i < NWTS; i++)
                weights[r][i] = '0;
        for (int i = 0; i < NWTS; i++) begin
            spec_sums[i]   = '0;
            commit_sums[i] = '0;
            path_rows[i]   = '0;
        end
        for (int t = 0; t < THREADS; t++) begin
            spec_hist[t]   = '0;
            commit_hist[t] = '0;
        end
        path_fill = 0;
        threshold = THR_RESET;
    endfunction

    function automatic void push_path(int row);
        for (int i = NWTS - 1; i > 0; i--)
            path_rows[i] = path_rows[i-1];
        path_rows[0] = ROW_W'(row);
        if (path_fill < NWTS) path_fill++;
    endfunction

    // shift the partial-sum pipeline one stage, folding in this row's weights
    function automatic void advance_partials(logic committed, int row, logic dir);
        psum_t nxt [NWTS];
        int    w;
        int    base;
        nxt[0] = '0;
        for (int i = 1; i < NWTS; i++) begin
            w      = int'(weights[row][NWTS-i]);
            base   = committed ? int'(commit_sums[i-1]) : int'(spec_sums[i-1]);
            nxt[i] = clip_sum(base + (dir ? w : -w));
        end
        if (committed) commit_sums = nxt;
        else           spec_sums   = nxt;
    endfunction

    function automatic outcome_t predict_outcome(logic [CMD_W-1:0] cmd,
                                                 logic [ADDR_W-1:0] addr, logic tk,
                                                 logic sq, logic [TID_W-1:0] tid);
        outcome_t               res;
        int                     row;
        int                     mag;
        int                     r;
        logic                   hb;
        logic [HISTORY_LEN-1:0] hist;
        res = '0;
        row = int'(addr % ROWS);
        if (int'(tid) < THREADS) begin
            case (cmd)
                CMD_LOOKUP: begin
                    push_path(row);
                    res.perceptron_sum = clip_sum(int'(weights[row][0]) +
                                                  int'(spec_sums[NWTS-1]));
                    res.predict_taken  = (res.perceptron_sum >= 0);
                    advance_partials(1'b0, row, res.predict_taken);
                    spec_hist[tid] = {spec_hist[tid][HISTORY_LEN-2:0], res.predict_taken};
                end
                CMD_UNCOND: begin
                    push_path(row);
                    spec_hist[tid]    = {spec_hist[tid][HISTORY_LEN-2:0], 1'b1};
                    res.predict_taken = 1'b1;
                end
                CMD_UPDATE: begin
                    hist = spec_hist[tid];
                    res.perceptron_sum = clip_sum(int'(weights[row][0]) +
                                                  int'(spec_sums[NWTS-1]));
                    advance_partials(1'b1, row, tk);
                    commit_hist[tid] = {commit_hist[tid][HISTORY_LEN-2:0], tk};
                    mag = (res.perceptron_sum < 0) ? -int'(res.perceptron_sum)
                                                   : int'(res.perceptron_sum);
                    if (sq || mag <= int'(threshold)) begin
                        if (sq) begin
                            spec_hist[tid] = commit_hist[tid];
                            spec_sums      = commit_sums;
                        end
                        weights[row][0] = nudge(weights[row][0], tk);
                        // empty path trains the bias alone; deepest bit reads as zero
                        if (path_fill > 0) begin
                            for (int j = 1; j < NWTS; j++) begin
                                r  = int'(path_rows[j % path_fill]) % ROWS;
                                hb = (j < HISTORY_LEN) ? hist[j] : 1'b0;
                                weights[r][j] = nudge(weights[r][j], hb == tk);
                            end
                        end
                        res.trained = 1'b1;
                    end
                end
                CMD_SQUASH: begin
                    spec_hist[tid] = commit_hist[tid];
                    spec_sums      = commit_sums;
                end
                CMD_BTB_FIX: begin
                    commit_hist[tid][0] = 1'b0;
                end
                default: begin
                end
            endcase
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        outcome_t want;
        outcome_t got;
        if (!i_rst_n) begin
            clear_state();
            outcome_q.delete();
            err_cnt     = 0;
            checked_cnt = 0;
            trained_cnt = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                threshold = i_cfg.data;
            if (i_res.valid && i_res.ready) begin
                got = {i_res.predict_taken, i_res.perceptron_sum, i_res.trained};
                if (outcome_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: result beat with nothing outstanding: taken=%0b sum=%0d trained=%0b",
                                 $realtime, got.predict_taken, got.perceptron_sum, got.trained);
                end else begin
                    want = outcome_q.pop_front();
                    checked_cnt++;
                    if (want.trained) trained_cnt++;
                    if (got.predict_taken !== want.predict_taken ||
                        got.perceptron_sum !== want.perceptron_sum ||
                        got.trained !== want.trained) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: result %0d mismatch: exp taken=%0b sum=%0d trained=%0b, got taken=%0b sum=%0d trained=%0b",
                                     $realtime, checked_cnt, want.predict_taken,
                                     want.perceptron_sum, want.trained, got.predict_taken,
                                     got.perceptron_sum, got.trained);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                outcome_q.push_back(predict_outcome(i_cmd.command, i_cmd.branch_address,
                                                    i_cmd.taken, i_cmd.was_squashed,
                                                    i_cmd.thread_id));
        end
        o_errors  <= err_cnt;
        o_pending <= outcome_q.size();
        o_checked <= checked_cnt;
        o_trained <= trained_cnt;
    end

endmodule

[verif/path_perceptron_branch_predictor_tb.sv]
module path_perceptron_branch_predictor_tb;
    import ppbp_pkg::*;

    localparam int HISTORY_LEN  = 16;
    localparam int ROWS         = 10;
    localparam int THREADS      = 4;
    localparam int WEIGHT_BITS  = 4;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1350;
    localparam int SEGMENTS     = 6;
    localparam int POOL         = 8;
    localparam int HOLD_SEGMENT = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int TIMEOUT      = 1_200_000;

    localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = '1;
    localparam logic [ADDR_W-1:0] ADDR_TOP_BIT  = {1'b1, {(ADDR_W-1){1'b0}}};

    // one threshold per random segment; the last one is drawn at run time
    localparam logic [THR_W-1:0] THR_PLAN [SEGMENTS] = '{11'd0, 11'd2047, 11'd20, 11'd56,
                                                        11'd700, 11'd0};

    logic clk;
    logic rst_n;

    ppbp_cmd_if cmd_bus ();
    ppbp_res_if res_bus ();
    ppbp_cfg_if cfg_bus ();

    int errors;
    int pending;
    int checked;
    int trains;

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_req_cnt;
    int sent_cnt;
    int directed_cnt;

    path_perceptron_branch_predictor #(
        .HISTORY_LEN (HISTORY_LEN),
        .ROWS        (ROWS),
        .THREADS     (THREADS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    ppbp_prediction_checker #(
        .HISTORY_LEN (HISTORY_LEN),
        .ROWS        (ROWS),
        .THREADS     (THREADS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_prediction_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cmd     (cmd_bus),
        .i_res     (res_bus),
        .i_cfg     (cfg_bus),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked),
        .o_trained (trains)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #TIMEOUT;
        $display("path_perceptron_branch_predictor_tb failed");
        $finish;
    end

    // result side: random backpressure, plus a long hold-off on request
    initial begin : result_side
        int hold_left;
        int hold_seen;
        hold_left     = 0;
        hold_seen     = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_branch(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                               input logic tk, input logic sq, input logic [TID_W-1:0] tid);
        while ($urandom_range(99) < snd_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.command        <= c;
        cmd_bus.branch_address <= a;
        cmd_bus.taken          <= tk;
        cmd_bus.was_squashed   <= sq;
        cmd_bus.thread_id      <= tid;
        do @(posedge clk); while (!cmd_bus.ready);
        sent_cnt++;
    endtask

    // pending is registered, so the task waits for a clock edge before sampling it
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [ADDR_W-1:0] hot_addr [POOL];
        logic              hot_dir  [POOL];
        logic [TID_W-1:0]  tid;
        logic [THR_W-1:0]  thr;
        int                k;
        int                pick;

        rst_n                  = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.command        = CMD_LOOKUP;
        cmd_bus.branch_address = '0;
        cmd_bus.taken          = 1'b0;
        cmd_bus.was_squashed   = 1'b0;
        cmd_bus.thread_id      = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.data           = '0;
        snd_idle_pct           = 18;
        rcv_idle_pct           = 73;
        hold_req_cnt           = 0;
        sent_cnt               = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-path update first, then reserved codes and field extremes
        send_branch(CMD_UPDATE, '0, 1'b1, 1'b0, 2'd0);
        for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
            send_branch(CMD_W'(c), ADDR_ALL_ONES, 1'b1, 1'b1, 2'd3);
        send_branch(CMD_LOOKUP, ADDR_ALL_ONES, 1'b0, 1'b0, 2'd3);
        send_branch(CMD_LOOKUP, '0, 1'b1, 1'b1, 2'd0);
        send_branch(CMD_UNCOND, ADDR_TOP_BIT, 1'b0, 1'b0, 2'd1);
        send_branch(CMD_UPDATE, ADDR_ALL_ONES, 1'b0, 1'b0, 2'd3);
        send_branch(CMD_UPDATE, '0, 1'b1, 1'b1, 2'd0);
        send_branch(CMD_SQUASH, ADDR_ALL_ONES, 1'b1, 1'b1, 2'd2);
        send_branch(CMD_SQUASH, '0, 1'b0, 1'b0, 2'd0);
        send_branch(CMD_BTB_FIX, '0, 1'b0, 1'b0, 2'd0);
        send_branch(CMD_BTB_FIX, ADDR_ALL_ONES, 1'b1, 1'b1, 2'd3);
        for (int r = 0; r < ROWS; r++)
            send_branch(CMD_LOOKUP, ADDR_W'(r), 1'b0, 1'b0, TID_W'(r));
        send_branch(CMD_UPDATE, ADDR_W'(3), 1'b1, 1'b0, 2'd1);
        cmd_bus.valid <= 1'b0;
        directed_cnt = sent_cnt;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // sender holds until every outstanding result is back before reconfiguring
            wait_drained();
            thr = (seg == SEGMENTS - 1) ? THR_W'($urandom_range(2047)) : THR_PLAN[seg];
            write_threshold(thr);
            if (seg < 2) begin
                snd_idle_pct = 18;
                rcv_idle_pct <= 73;
            end else if (seg < 4) begin
                snd_idle_pct = 73;
                rcv_idle_pct <= 18;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct <= 0;
            end
            for (int i = 0; i < POOL; i++) begin
                hot_addr[i] = ADDR_W'({$urandom, $urandom});
                hot_dir[i]  = $urandom_range(1);
            end

            for (int n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) begin
                if (seg == HOLD_SEGMENT && n == 30)
                    hold_req_cnt <= hold_req_cnt + 1;
                k    = $urandom_range(POOL - 1);
                pick = $urandom_range(99);
                tid  = $urandom_range(TID_N - 1);
                // mostly lookups and biased resolves on a few hot branches
                if (pick < 38)
                    send_branch(CMD_LOOKUP, hot_addr[k], $urandom_range(1),
                                $urandom_range(1), tid);
                else if (pick < 68)
                    send_branch(CMD_UPDATE, hot_addr[k],
                                ($urandom_range(99) < 85) ? hot_dir[k] : !hot_dir[k],
                                $urandom_range(99) < 12, tid);
                else if (pick < 76)
                    send_branch(CMD_UNCOND, hot_addr[k], $urandom_range(1),
                                $urandom_range(1), tid);
                else if (pick < 82)
                    send_branch(CMD_SQUASH, ADDR_W'({$urandom, $urandom}),
                                $urandom_range(1), $urandom_range(1), tid);
                else if (pick < 88)
                    send_branch(CMD_BTB_FIX, ADDR_W'({$urandom, $urandom}),
                                $urandom_range(1), $urandom_range(1), tid);
                else if (pick < 96)
                    send_branch(($urandom_range(1) != 0) ? CMD_LOOKUP : CMD_UPDATE,
                                ADDR_W'({$urandom, $urandom}), $urandom_range(1),
                                $urandom_range(1), tid);
                else
                    send_branch(CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO)),
                                ADDR_W'({$urandom, $urandom}), $urandom_range(1),
                                $urandom_range(1), tid);
            end
            cmd_bus.valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands (%0d directed) across %0d threshold settings and three idle profiles,",
                 sent_cnt, directed_cnt, SEGMENTS + 1);
        $display("checking %0d results, %0d of them weight-training updates.", checked, trains);
        if (errors == 0 && pending == 0)
            $display("path_perceptron_branch_predictor_tb passed");
        else
            $display("path_perceptron_branch_predictor_tb failed");
        $finish;
    end

endmodule
